@@ rtl/core/rlct_pkg.sv @@
// shared types, constants and helper functions for the retry level collision tracker
// no dependencies; imported by the top level
package rlct_pkg;

    // sizing
    localparam int MAX_SENSORS  = 1024;
    localparam int RETRY_LEVELS = 7;

    localparam int IDX_W  = $clog2(MAX_SENSORS);
    localparam int CNT_W  = $clog2(MAX_SENSORS + 1);
    localparam int LVL_W  = $clog2(2 * RETRY_LEVELS);
    localparam int CIDX_W = $clog2(RETRY_LEVELS);

    // field widths
    localparam int KIND_W      = 2;
    localparam int SENSOR_W    = 10;
    localparam int STAT_LVL_W  = 3;
    localparam int OUT_LVL_W   = 4;
    localparam int DC_W        = 2;
    localparam int STAT_CNT_W  = 32;
    localparam int PKT_W       = 16;
    localparam int SCOUNT_W    = 11;
    localparam int GOAL_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    localparam int IN_TDATA_W      = ((SENSOR_W + STAT_LVL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_RAW_W = SENSOR_W + 1 + DC_W + 1 + 1 + OUT_LVL_W + 1
                                     + 2 * STAT_CNT_W;
    localparam int OUT_TDATA_W     = ((OUT_TDATA_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W       = OUT_TDATA_W - OUT_TDATA_RAW_W;

    // register reset values
    localparam logic [SCOUNT_W-1:0] SENSOR_COUNT_RESET = SCOUNT_W'(5);
    localparam logic [GOAL_W-1:0]   PACKET_GOAL_RESET  = GOAL_W'(1000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_GOAL  = 1'b1;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_END   = 2'd1,
        KIND_STAT  = 2'd2
    } kind_t;

    // scheduled event kinds
    localparam logic NEXT_START = 1'b0;
    localparam logic NEXT_END   = 1'b1;

    // delay classes
    localparam logic [DC_W-1:0] DC_EMIT    = 2'd0;
    localparam logic [DC_W-1:0] DC_BACKOFF = 2'd1;
    localparam logic [DC_W-1:0] DC_IDLE    = 2'd2;

    localparam logic [LVL_W-1:0] LEVEL_IDLE = '0;

    // memory sweep sequencer
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_COUNT
    } sweep_state_t;

    // per-sender memory entry
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [PKT_W-1:0] pkts;
    } mem_entry_t;

    localparam int MEM_W = $bits(mem_entry_t);

    // record of a recent memory write, for read forwarding
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] addr;
        mem_entry_t       data;
    } fwd_t;

    typedef struct packed {
        logic                  valid_action;
        logic [SENSOR_W-1:0]   target_sensor;
        logic                  next_kind;
        logic [DC_W-1:0]       delay_class;
        logic                  cancel_end;
        logic                  collision;
        logic [OUT_LVL_W-1:0]  new_level;
        logic                  last;
        logic                  all_done;
        logic [STAT_CNT_W-1:0] attempt_count;
        logic [STAT_CNT_W-1:0] collision_count;
    } result_t;

    // saturating add of 0, 1 or 2
    function automatic logic [STAT_CNT_W-1:0] sat_add(input logic [STAT_CNT_W-1:0] v,
                                                      input logic [1:0] amt);
        logic [STAT_CNT_W:0] sum;
        sum = {1'b0, v} + (STAT_CNT_W + 1)'(amt);
        return sum[STAT_CNT_W] ? '1 : sum[STAT_CNT_W-1:0];
    endfunction

    // level after a collision during attempt a
    function automatic logic [LVL_W-1:0] after_collision(input logic [LVL_W-1:0] a);
        return (32'(a) >= RETRY_LEVELS) ? LEVEL_IDLE : LVL_W'(RETRY_LEVELS) + a;
    endfunction

endpackage

@@ rtl/core/rlct_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module rlct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/retry_level_collision_tracker_top.sv @@
// top level of the retry level collision tracker: request decode, channel state,
// per-level counters and result buffering; uses rlct_pkg and rlct_ram
// an accepted request is held in the request stage and commits its results to the output register
// throughput: one request per cycle while results are taken; a collision pair blocks commits
// the per-sender state ram is read at accept and written back when the request commits
// reset: async active low; then a clearing pass zeroes all MAX_SENSORS ram entries,
// and each register write starts a recount of done senders; no requests meanwhile
module retry_level_collision_tracker_top
    import rlct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sensor, stat_level, zero pad
    input  logic [KIND_W-1:0]      s_axis_tuser,   // kind

    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // target_sensor, next_kind, delay_class,
                                                   // cancel_end, collision, new_level,
                                                   // all_done, attempt_count,
                                                   // collision_count, zero pad
    output logic                   m_axis_tuser,   // valid_action
    output logic                   m_axis_tlast,   // last

    // register write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    sweep_state_t              state_reg, state_next;
    logic [CNT_W-1:0]          swp_cnt_reg, swp_cnt_next;
    logic                      cnt_vld_reg, cnt_vld_next;
    logic [IDX_W-1:0]          cnt_idx_reg, cnt_idx_next;

    logic [SCOUNT_W-1:0]       sensor_count_reg, sensor_count_next;
    logic [GOAL_W-1:0]         packet_goal_reg, packet_goal_next;

    logic                      s1_valid_reg, s1_valid_next;
    logic [KIND_W-1:0]         s1_kind_reg, s1_kind_next;
    logic [SENSOR_W-1:0]       s1_sensor_reg, s1_sensor_next;
    logic [STAT_LVL_W-1:0]     s1_stat_reg, s1_stat_next;

    logic                      busy_reg, busy_next;
    logic [SENSOR_W-1:0]       holder_reg, holder_next;
    logic [LVL_W-1:0]          hlvl_reg, hlvl_next;
    logic [PKT_W-1:0]          hpkts_reg, hpkts_next;
    logic [CNT_W-1:0]          done_reg, done_next;
    logic [STAT_CNT_W-1:0]     att_cnt_reg [RETRY_LEVELS];
    logic [STAT_CNT_W-1:0]     att_cnt_next [RETRY_LEVELS];
    logic [STAT_CNT_W-1:0]     col_cnt_reg [RETRY_LEVELS];
    logic [STAT_CNT_W-1:0]     col_cnt_next [RETRY_LEVELS];

    // deferred write of the holder's entry after a collision
    logic                      hw_valid_reg, hw_valid_next;
    logic [IDX_W-1:0]          hw_addr_reg, hw_addr_next;
    mem_entry_t                hw_data_reg, hw_data_next;

    // last two ram writes, newest first
    fwd_t                      fwd0_reg, fwd0_next;
    fwd_t                      fwd1_reg, fwd1_next;

    // output register and second slot for the collision pair
    logic                      out_valid_reg, out_valid_next;
    result_t                   out_data_reg, out_data_next;
    logic                      pend_valid_reg, pend_valid_next;
    result_t                   pend_data_reg, pend_data_next;

    // ------------------------------------------------------------------
    // combinational signals
    // ------------------------------------------------------------------
    logic                      clear_we;
    logic                      cnt_rd;
    logic                      run;
    logic [IDX_W-1:0]          swp_idx;

    logic                      accept;
    logic                      commit;
    logic                      out_take;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    mem_entry_t                ram_wdata;
    logic                      ram_re;
    logic [IDX_W-1:0]          ram_raddr;
    logic [MEM_W-1:0]          ram_rdata;
    mem_entry_t                ram_ent;
    mem_entry_t                ent;

    logic [CNT_W-1:0]          in_use;
    logic                      in_range;
    logic                      ad_cur;

    logic                      start_ok;
    logic [LVL_W-1:0]          att;
    logic [LVL_W-1:0]          hn;
    logic [LVL_W-1:0]          sn;
    logic                      pk_sat;
    logic                      hit_goal;
    logic                      cnt_hit;

    result_t                   noact;
    result_t                   ev_r0;
    result_t                   ev_r1;
    logic                      ev_two;
    logic                      ev_we;
    mem_entry_t                ev_ent;
    logic                      ev_busy;
    logic [SENSOR_W-1:0]       ev_holder;
    logic [LVL_W-1:0]          ev_hlvl;
    logic [PKT_W-1:0]          ev_hpkts;
    logic [CNT_W-1:0]          ev_done;
    logic                      ev_att_inc;
    logic                      ev_coll;
    logic                      ev_hw;

    // ------------------------------------------------------------------
    // per-sender state ram: level and delivered packets
    // ------------------------------------------------------------------
    rlct_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_SENSORS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_ent = ram_rdata;

    // ------------------------------------------------------------------
    // sweep sequencer: clearing pass after reset, recount after register writes
    // ------------------------------------------------------------------
    assign swp_idx = swp_cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (swp_cnt_reg == CNT_W'(MAX_SENSORS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cfg_we)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (!cfg_we && swp_cnt_reg == CNT_W'(MAX_SENSORS) && !cnt_vld_reg)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clear_we = 1'b0;
        cnt_rd   = 1'b0;
        run      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_we = 1'b1;
            end
            ST_RUN:
            begin
                run = 1'b1;
            end
            ST_COUNT:
            begin
                cnt_rd = (32'(swp_cnt_reg) < MAX_SENSORS);
            end
            default:
            begin
                clear_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign out_take      = out_valid_reg && m_axis_tready;
    // a request commits once the output register has room for all its results
    assign commit        = s1_valid_reg && !pend_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = run && (!s1_valid_reg || commit);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // ram ports
    // ------------------------------------------------------------------
    assign ram_re    = accept || cnt_rd;
    assign ram_raddr = cnt_rd ? swp_idx : IDX_W'(s_axis_tdata[SENSOR_W-1:0]);

    always_comb
    begin
        if (clear_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = swp_idx;
            ram_wdata = '0;
        end
        else if (hw_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = hw_addr_reg;
            ram_wdata = hw_data_reg;
        end
        else
        begin
            ram_we    = commit && ev_we;
            ram_waddr = IDX_W'(s1_sensor_reg);
            ram_wdata = ev_ent;
        end
    end

    // read data corrected for writes that landed at or after the read
    always_comb
    begin
        if (fwd0_reg.valid && fwd0_reg.addr == IDX_W'(s1_sensor_reg))
        begin
            ent = fwd0_reg.data;
        end
        else if (fwd1_reg.valid && fwd1_reg.addr == IDX_W'(s1_sensor_reg))
        begin
            ent = fwd1_reg.data;
        end
        else
        begin
            ent = ram_ent;
        end
    end

    // ------------------------------------------------------------------
    // request evaluation
    // ------------------------------------------------------------------
    assign in_use   = (32'(sensor_count_reg) > MAX_SENSORS) ? CNT_W'(MAX_SENSORS)
                                                             : CNT_W'(sensor_count_reg);
    assign in_range = (32'(s1_sensor_reg) < 32'(in_use));
    assign ad_cur   = (32'(done_reg) >= 32'(in_use));

    // attempt level entered by a start: from idle, or from a wait level
    always_comb
    begin
        start_ok = 1'b0;
        att      = LEVEL_IDLE;
        if (ent.level == LEVEL_IDLE)
        begin
            start_ok = 1'b1;
            att      = LVL_W'(1);
        end
        else if (32'(ent.level) > RETRY_LEVELS && 32'(ent.level) < 2 * RETRY_LEVELS)
        begin
            start_ok = 1'b1;
            att      = ent.level - LVL_W'(RETRY_LEVELS) + LVL_W'(1);
        end
    end

    assign hn       = after_collision(hlvl_reg);
    assign sn       = after_collision(att);
    assign pk_sat   = (ent.pkts == '1);
    assign hit_goal = !pk_sat && (ent.pkts == packet_goal_reg);

    always_comb
    begin
        noact          = '0;
        noact.last     = 1'b1;
        noact.all_done = ad_cur;

        ev_r0      = noact;
        ev_r1      = noact;
        ev_two     = 1'b0;
        ev_we      = 1'b0;
        ev_ent     = ent;
        ev_busy    = busy_reg;
        ev_holder  = holder_reg;
        ev_hlvl    = hlvl_reg;
        ev_hpkts   = hpkts_reg;
        ev_done    = done_reg;
        ev_att_inc = 1'b0;
        ev_coll    = 1'b0;
        ev_hw      = 1'b0;

        case (s1_kind_reg)
            KIND_STAT:
            begin
                if (32'(s1_stat_reg) < RETRY_LEVELS)
                begin
                    ev_r0.attempt_count   = att_cnt_reg[CIDX_W'(s1_stat_reg)];
                    ev_r0.collision_count = col_cnt_reg[CIDX_W'(s1_stat_reg)];
                end
            end
            KIND_START:
            begin
                if (in_range && start_ok)
                begin
                    ev_we      = 1'b1;
                    ev_att_inc = 1'b1;
                    if (!busy_reg)
                    begin
                        // channel free: take it and ask for the end of emission
                        ev_ent.level        = att;
                        ev_busy             = 1'b1;
                        ev_holder           = s1_sensor_reg;
                        ev_hlvl             = att;
                        ev_hpkts            = ent.pkts;
                        ev_r0.valid_action  = 1'b1;
                        ev_r0.target_sensor = s1_sensor_reg;
                        ev_r0.next_kind     = NEXT_END;
                        ev_r0.delay_class   = DC_EMIT;
                        ev_r0.new_level     = OUT_LVL_W'(att);
                    end
                    else
                    begin
                        // collision: holder first, then the newcomer
                        ev_ent.level        = sn;
                        ev_busy             = 1'b0;
                        ev_coll             = 1'b1;
                        ev_hw               = 1'b1;
                        ev_two              = 1'b1;
                        ev_r0.valid_action  = 1'b1;
                        ev_r0.target_sensor = holder_reg;
                        ev_r0.next_kind     = NEXT_START;
                        ev_r0.delay_class   = (hn == LEVEL_IDLE) ? DC_IDLE : DC_BACKOFF;
                        ev_r0.cancel_end    = 1'b1;
                        ev_r0.collision     = 1'b1;
                        ev_r0.new_level     = OUT_LVL_W'(hn);
                        ev_r0.last          = 1'b0;
                        ev_r1.valid_action  = 1'b1;
                        ev_r1.target_sensor = s1_sensor_reg;
                        ev_r1.next_kind     = NEXT_START;
                        ev_r1.delay_class   = (sn == LEVEL_IDLE) ? DC_IDLE : DC_BACKOFF;
                        ev_r1.collision     = 1'b1;
                        ev_r1.new_level     = OUT_LVL_W'(sn);
                    end
                end
            end
            KIND_END:
            begin
                if (in_range && busy_reg && holder_reg == s1_sensor_reg)
                begin
                    ev_we        = 1'b1;
                    ev_ent.level = LEVEL_IDLE;
                    if (!pk_sat)
                    begin
                        ev_ent.pkts = ent.pkts + PKT_W'(1);
                    end
                    if (hit_goal)
                    begin
                        ev_done = done_reg + CNT_W'(1);
                    end
                    ev_busy             = 1'b0;
                    ev_r0.valid_action  = 1'b1;
                    ev_r0.target_sensor = s1_sensor_reg;
                    ev_r0.next_kind     = NEXT_START;
                    ev_r0.delay_class   = DC_IDLE;
                end
            end
            default:
            begin
                ev_we = 1'b0;
            end
        endcase

        ev_r0.all_done = (32'(ev_done) >= 32'(in_use));
        ev_r1.all_done = (32'(ev_done) >= 32'(in_use));
    end

    // recount: sender in use whose delivered packets exceed the goal
    assign cnt_hit = cnt_vld_reg && (32'(cnt_idx_reg) < 32'(in_use))
                     && (ram_ent.pkts > packet_goal_reg);

    // ------------------------------------------------------------------
    // next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        swp_cnt_next      = swp_cnt_reg;
        cnt_vld_next      = cnt_rd && !cfg_we;
        cnt_idx_next      = swp_idx;
        sensor_count_next = sensor_count_reg;
        packet_goal_next  = packet_goal_reg;

        s1_valid_next  = s1_valid_reg;
        s1_kind_next   = s1_kind_reg;
        s1_sensor_next = s1_sensor_reg;
        s1_stat_next   = s1_stat_reg;

        busy_next    = busy_reg;
        holder_next  = holder_reg;
        hlvl_next    = hlvl_reg;
        hpkts_next   = hpkts_reg;
        done_next    = done_reg;
        att_cnt_next = att_cnt_reg;
        col_cnt_next = col_cnt_reg;

        hw_valid_next = commit && ev_hw;
        hw_addr_next  = IDX_W'(holder_reg);
        hw_data_next  = '{level: hn, pkts: hpkts_reg};

        fwd0_next = fwd0_reg;
        fwd1_next = fwd1_reg;

        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;

        // register writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SENSOR_COUNT:
                begin
                    sensor_count_next = cfg_data[SCOUNT_W-1:0];
                end
                REG_PACKET_GOAL:
                begin
                    packet_goal_next = cfg_data[GOAL_W-1:0];
                end
                default:
                begin
                    sensor_count_next = sensor_count_reg;
                end
            endcase
        end

        // sweep counter and recount
        case (state_reg)
            ST_CLEAR:
            begin
                swp_cnt_next = swp_cnt_reg + CNT_W'(1);
            end
            ST_RUN:
            begin
                if (cfg_we)
                begin
                    swp_cnt_next = '0;
                    done_next    = '0;
                end
            end
            ST_COUNT:
            begin
                if (cfg_we)
                begin
                    swp_cnt_next = '0;
                    done_next    = '0;
                end
                else
                begin
                    if (cnt_rd)
                    begin
                        swp_cnt_next = swp_cnt_reg + CNT_W'(1);
                    end
                    if (cnt_hit)
                    begin
                        done_next = done_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                swp_cnt_next = '0;
            end
        endcase

        // request stage
        if (accept)
        begin
            s1_valid_next  = 1'b1;
            s1_kind_next   = s_axis_tuser;
            s1_sensor_next = s_axis_tdata[SENSOR_W-1:0];
            s1_stat_next   = s_axis_tdata[SENSOR_W +: STAT_LVL_W];
        end
        else if (commit)
        begin
            s1_valid_next = 1'b0;
        end

        // channel state and counters
        if (commit)
        begin
            busy_next   = ev_busy;
            holder_next = ev_holder;
            hlvl_next   = ev_hlvl;
            hpkts_next  = ev_hpkts;
            done_next   = ev_done;
            for (int i = 0; i < RETRY_LEVELS; i++)
            begin
                att_cnt_next[i] = sat_add(att_cnt_reg[i],
                    {1'b0, ev_att_inc && att == LVL_W'(i + 1)});
                col_cnt_next[i] = sat_add(col_cnt_reg[i],
                    2'(ev_coll && hlvl_reg == LVL_W'(i + 1))
                    + 2'(ev_coll && att == LVL_W'(i + 1)));
            end
        end

        // forwarding history follows every ram write
        if (ram_we)
        begin
            fwd1_next = fwd0_reg;
            fwd0_next = '{valid: 1'b1, addr: ram_waddr, data: ram_wdata};
        end

        // result buffering
        if (commit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = ev_r0;
            if (ev_two)
            begin
                pend_valid_next = 1'b1;
                pend_data_next  = ev_r1;
            end
        end
        else if (out_take)
        begin
            if (pend_valid_reg)
            begin
                out_data_next   = pend_data_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            swp_cnt_reg      <= '0;
            cnt_vld_reg      <= 1'b0;
            sensor_count_reg <= SENSOR_COUNT_RESET;
            packet_goal_reg  <= PACKET_GOAL_RESET;
            s1_valid_reg     <= 1'b0;
            busy_reg         <= 1'b0;
            holder_reg       <= '0;
            hlvl_reg         <= LEVEL_IDLE;
            hpkts_reg        <= '0;
            done_reg         <= '0;
            for (int i = 0; i < RETRY_LEVELS; i++)
            begin
                att_cnt_reg[i] <= '0;
                col_cnt_reg[i] <= '0;
            end
            hw_valid_reg     <= 1'b0;
            fwd0_reg         <= '0;
            fwd1_reg         <= '0;
            out_valid_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            swp_cnt_reg      <= swp_cnt_next;
            cnt_vld_reg      <= cnt_vld_next;
            sensor_count_reg <= sensor_count_next;
            packet_goal_reg  <= packet_goal_next;
            s1_valid_reg     <= s1_valid_next;
            busy_reg         <= busy_next;
            holder_reg       <= holder_next;
            hlvl_reg         <= hlvl_next;
            hpkts_reg        <= hpkts_next;
            done_reg         <= done_next;
            att_cnt_reg      <= att_cnt_next;
            col_cnt_reg      <= col_cnt_next;
            hw_valid_reg     <= hw_valid_next;
            fwd0_reg         <= fwd0_next;
            fwd1_reg         <= fwd1_next;
            out_valid_reg    <= out_valid_next;
            pend_valid_reg   <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_idx_reg    <= cnt_idx_next;
        s1_kind_reg    <= s1_kind_next;
        s1_sensor_reg  <= s1_sensor_next;
        s1_stat_reg    <= s1_stat_next;
        hw_addr_reg    <= hw_addr_next;
        hw_data_reg    <= hw_data_next;
        out_data_reg   <= out_data_next;
        pend_data_reg  <= pend_data_next;
    end

    // ------------------------------------------------------------------
    // result port
    // ------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.valid_action;
    assign m_axis_tlast  = out_data_reg.last;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}},
                            out_data_reg.collision_count,
                            out_data_reg.attempt_count,
                            out_data_reg.all_done,
                            out_data_reg.new_level,
                            out_data_reg.collision,
                            out_data_reg.cancel_end,
                            out_data_reg.delay_class,
                            out_data_reg.next_kind,
                            out_data_reg.target_sensor};

endmodule

@@ tb/retry_level_collision_tracker_top_test.sv @@
`timescale 1ns / 100ps
// self-checking bench for retry_level_collision_tracker_top: stream driver, result monitor,
// and a tracker of channel, per-sender and per-level state that predicts every result
// depends on rlct_pkg and the top level of the block
module retry_level_collision_tracker_top_test;
    import rlct_pkg::*;

    // kind code the block answers with a no-action result
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned SWEEP_WAIT  = MAX_SENSORS + 8;

    // one request as the generator sees it
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SENSOR_W-1:0]   sensor;
        logic [STAT_LVL_W-1:0] stat_lvl;
    } request_t;

    // result tdata layout, highest bits first
    typedef struct packed {
        logic [OUT_PAD_W-1:0]  pad;
        logic [STAT_CNT_W-1:0] collision_count;
        logic [STAT_CNT_W-1:0] attempt_count;
        logic                  all_done;
        logic [OUT_LVL_W-1:0]  new_level;
        logic                  collision;
        logic                  cancel_end;
        logic [DC_W-1:0]       delay_class;
        logic                  next_kind;
        logic [SENSOR_W-1:0]   target_sensor;
    } result_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // knobs owned by the main sequence, sampled by the driver and monitor
    logic sender_idles;
    logic receiver_stalls;
    logic hold_kick;

    // tracker state: configuration, channel, per-sender and per-level counters
    int unsigned           fleet_size;
    int unsigned           packet_goal;
    int unsigned           done_count;
    logic                  channel_taken;
    int unsigned           channel_owner;
    logic [OUT_LVL_W-1:0]  sender_state [MAX_SENSORS];
    logic [PKT_W-1:0]      delivered    [MAX_SENSORS];
    logic [STAT_CNT_W-1:0] level_attempts   [RETRY_LEVELS];
    logic [STAT_CNT_W-1:0] level_collisions [RETRY_LEVELS];

    request_t    waiting_requests [$];
    result_t     predicted_results [$];
    request_t    on_offer;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned requests_taken;
    int unsigned results_seen;
    int unsigned collision_events;
    int unsigned register_writes;
    int unsigned deepest_level;

    retry_level_collision_tracker_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // tracker of the block
    // ---------------------------------------------------------------

    // register values above the sender table size act as a full table
    function automatic int unsigned senders_in_use();
        return (fleet_size < MAX_SENSORS) ? fleet_size : MAX_SENSORS;
    endfunction

    function automatic logic fleet_done();
        return done_count >= senders_in_use();
    endfunction

    function automatic logic [STAT_CNT_W-1:0] count_up(input logic [STAT_CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // wait level after a collision in attempt a; the last attempt drops to idle
    function automatic int unsigned backoff_level(input int unsigned a);
        return (a >= RETRY_LEVELS) ? 0 : RETRY_LEVELS + a;
    endfunction

    task automatic recount_done();
        int unsigned k;
        done_count = 0;
        for (k = 0; k < senders_in_use(); k++)
            if (delivered[k] > packet_goal)
                done_count++;
    endtask

    // apply one accepted request and queue the one or two results it causes
    task automatic track_event(input request_t rq);
        result_t     first;
        result_t     second;
        logic        two;
        int unsigned s;
        int unsigned lv;
        int unsigned att;
        int unsigned hl;
        int unsigned hn;
        int unsigned sn;
        int unsigned p;
        first  = '0;
        second = '0;
        two    = 1'b0;
        first.last = 1'b1;
        s = rq.sensor;
        if (rq.kind == KIND_STAT)
        begin
            // levels past the last attempt read as zero
            if (rq.stat_lvl < RETRY_LEVELS)
            begin
                first.attempt_count   = level_attempts[rq.stat_lvl];
                first.collision_count = level_collisions[rq.stat_lvl];
            end
        end
        else if (rq.kind == KIND_UNUSED || s >= senders_in_use())
        begin
            // unknown kind or sender not in use: no action
        end
        else if (rq.kind == KIND_START)
        begin
            lv  = sender_state[s];
            att = 0;
            if (lv == LEVEL_IDLE)
                att = 1;
            else if (lv > RETRY_LEVELS && lv < 2 * RETRY_LEVELS)
                att = lv - RETRY_LEVELS + 1;
            // a start during an attempt leaves att at zero and is ignored
            if (att != 0)
            begin
                sender_state[s]       = OUT_LVL_W'(att);
                level_attempts[att-1] = count_up(level_attempts[att-1]);
                if (!channel_taken)
                begin
                    channel_taken = 1'b1;
                    channel_owner = s;
                    first.valid_action  = 1'b1;
                    first.target_sensor = SENSOR_W'(s);
                    first.next_kind     = NEXT_END;
                    first.delay_class   = DC_EMIT;
                    first.new_level     = OUT_LVL_W'(att);
                end
                else
                begin
                    // both sides of the collision back off, the holder loses its end
                    hl = sender_state[channel_owner];
                    hn = 0;
                    if (hl >= 1 && hl <= RETRY_LEVELS)
                    begin
                        level_collisions[hl-1] = count_up(level_collisions[hl-1]);
                        hn = backoff_level(hl);
                    end
                    level_collisions[att-1] = count_up(level_collisions[att-1]);
                    channel_taken = 1'b0;
                    sender_state[channel_owner] = OUT_LVL_W'(hn);
                    sn = backoff_level(att);
                    sender_state[s] = OUT_LVL_W'(sn);
                    first.valid_action  = 1'b1;
                    first.target_sensor = SENSOR_W'(channel_owner);
                    first.next_kind     = NEXT_START;
                    first.delay_class   = (hn == 0) ? DC_IDLE : DC_BACKOFF;
                    first.cancel_end    = 1'b1;
                    first.collision     = 1'b1;
                    first.new_level     = OUT_LVL_W'(hn);
                    first.last          = 1'b0;
                    second.valid_action  = 1'b1;
                    second.target_sensor = SENSOR_W'(s);
                    second.next_kind     = NEXT_START;
                    second.delay_class   = (sn == 0) ? DC_IDLE : DC_BACKOFF;
                    second.collision     = 1'b1;
                    second.new_level     = OUT_LVL_W'(sn);
                    second.last          = 1'b1;
                    two = 1'b1;
                end
            end
        end
        else if (channel_taken && channel_owner == s)
        begin
            // end of emission by the holder: one more packet, sender back to idle
            p = delivered[s];
            if (p < 16'hFFFF)
            begin
                if (p <= packet_goal && p + 1 > packet_goal)
                    done_count++;
                delivered[s] = PKT_W'(p + 1);
            end
            channel_taken   = 1'b0;
            sender_state[s] = LEVEL_IDLE;
            first.valid_action  = 1'b1;
            first.target_sensor = SENSOR_W'(s);
            first.next_kind     = NEXT_START;
            first.delay_class   = DC_IDLE;
            first.new_level     = LEVEL_IDLE;
        end
        first.all_done  = fleet_done();
        second.all_done = fleet_done();
        predicted_results.push_back(first);
        if (two)
            predicted_results.push_back(second);
    endtask

    // ---------------------------------------------------------------
    // request driver: bursts with random gaps, fed from waiting_requests
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_event(on_offer);
                requests_taken++;
            end
            // free to present the next request
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (waiting_requests.size() > 0)
                begin
                    on_offer = waiting_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'({on_offer.stat_lvl, on_offer.sensor});
                    s_axis_tuser  <= on_offer.kind;
                    if (burst_left > 0)
                        burst_left--;
                    else if (sender_idles)
                    begin
                        burst_left = $urandom_range(12, 0);
                        gap_left   = $urandom_range(8, 1);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ---------------------------------------------------------------
    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input result_word_t w, input logic got_valid,
                                input logic got_last);
        result_t want;
        if (predicted_results.size() == 0)
        begin
            $error("result with nothing expected: target %0d level %0d",
                   w.target_sensor, w.new_level);
            mismatch_count++;
            return;
        end
        want = predicted_results.pop_front();
        compare_field("valid_action", want.valid_action, got_valid);
        compare_field("target_sensor", want.target_sensor, w.target_sensor);
        compare_field("next_kind", want.next_kind, w.next_kind);
        compare_field("delay_class", want.delay_class, w.delay_class);
        compare_field("cancel_end", want.cancel_end, w.cancel_end);
        compare_field("collision", want.collision, w.collision);
        compare_field("new_level", want.new_level, w.new_level);
        compare_field("last", want.last, got_last);
        compare_field("all_done", want.all_done, w.all_done);
        compare_field("attempt_count", want.attempt_count, w.attempt_count);
        compare_field("collision_count", want.collision_count, w.collision_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                w = m_axis_tdata;
                check_result(w, m_axis_tuser, m_axis_tlast);
                results_seen++;
                if (w.collision && m_axis_tlast)
                    collision_events++;
                if (m_axis_tuser && w.new_level <= RETRY_LEVELS && w.new_level > deepest_level)
                    deepest_level = w.new_level;
            end
            // long hold-off lets the block fill up and push back on requests
            if (hold_kick)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (receiver_stalls && $urandom_range(3, 0) == 0)
            begin
                stall_left = $urandom_range(4, 0);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("retry_level_collision_tracker_top_test: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic add_request(input logic [KIND_W-1:0] kind, input int unsigned sensor,
                               input int unsigned lvl);
        request_t rq;
        rq.kind     = kind;
        rq.sensor   = SENSOR_W'(sensor);
        rq.stat_lvl = STAT_LVL_W'(lvl);
        waiting_requests.push_back(rq);
    endtask

    function automatic int unsigned any_sender(input int unsigned n);
        return (n == 0) ? $urandom_range(MAX_SENSORS - 1, 0) : $urandom_range(n - 1, 0);
    endfunction

    // mostly well-formed traffic: emit/end pairs and collision ladders,
    // then loose starts and ends, statistics reads and some noise
    task automatic queue_random(input int unsigned target);
        int unsigned made;
        int unsigned pick;
        int unsigned n;
        int unsigned a;
        int unsigned b;
        int unsigned reps;
        made = 0;
        n = senders_in_use();
        @(negedge clk);
        while (made < target)
        begin
            pick = $urandom_range(99, 0);
            a = any_sender(n);
            b = any_sender(n);
            if (pick < 30)
            begin
                add_request(KIND_START, a, $urandom_range(7, 0));
                add_request(KIND_END, a, $urandom_range(7, 0));
                made += 2;
            end
            else if (pick < 50)
            begin
                // alternate two senders so they climb the attempt levels together
                reps = $urandom_range(7, 1);
                repeat (reps)
                begin
                    add_request(KIND_START, a, $urandom_range(7, 0));
                    add_request(KIND_START, b, $urandom_range(7, 0));
                end
                made += 2 * reps;
            end
            else if (pick < 75)
            begin
                add_request($urandom_range(1, 0) ? KIND_END : KIND_START, a,
                            $urandom_range(7, 0));
                made++;
            end
            else if (pick < 88)
            begin
                add_request(KIND_STAT, $urandom_range(MAX_SENSORS - 1, 0), $urandom_range(7, 0));
                made++;
            end
            else if (n < MAX_SENSORS && $urandom_range(1, 0))
            begin
                // sender outside the range in use
                add_request($urandom_range(1, 0) ? KIND_END : KIND_START,
                            $urandom_range(MAX_SENSORS - 1, n), $urandom_range(7, 0));
            end
            else
            begin
                add_request(KIND_UNUSED, $urandom_range(MAX_SENSORS - 1, 0), $urandom_range(7, 0));
            end
        end
    endtask

    // wait until every request went out and every result came back
    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (waiting_requests.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // register write while idle; the block recounts done senders afterwards
    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SENSOR_COUNT)
            fleet_size = value[SCOUNT_W-1:0];
        else
            packet_goal = value[GOAL_W-1:0];
        recount_done();
        register_writes++;
        repeat (SWEEP_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idling(input logic sender_on, input logic receiver_on);
        @(posedge clk);
        sender_idles    <= sender_on;
        receiver_stalls <= receiver_on;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int unsigned k;
        int unsigned top_packets;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_SENSOR_COUNT;
        cfg_data        <= '0;
        sender_idles    <= 1'b1;
        receiver_stalls <= 1'b1;
        hold_kick       <= 1'b0;
        fleet_size    = SENSOR_COUNT_RESET;
        packet_goal   = PACKET_GOAL_RESET;
        done_count    = 0;
        channel_taken = 1'b0;
        channel_owner = 0;
        for (k = 0; k < MAX_SENSORS; k++)
        begin
            sender_state[k] = LEVEL_IDLE;
            delivered[k]    = '0;
        end
        for (k = 0; k < RETRY_LEVELS; k++)
        begin
            level_attempts[k]   = '0;
            level_collisions[k] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // clearing pass of the sender table
        repeat (SWEEP_WAIT) @(posedge clk);
        @(negedge clk);

        // directed checks on the reset configuration (five senders)
        add_request(KIND_STAT, 0, 0);          // counters start at zero
        add_request(KIND_START, 0, 7);         // free channel, stat bits ignored
        add_request(KIND_START, 0, 0);         // start during an attempt
        add_request(KIND_END, 1, 0);           // end from a sender not holding
        add_request(KIND_START, 4, 0);         // collides with the holder
        add_request(KIND_START, 0, 0);         // back from wait to attempt two
        add_request(KIND_END, 0, 0);           // delivered packet
        add_request(KIND_START, 5, 0);         // first index out of use
        add_request(KIND_END, 1023, 7);        // top index, all bits high
        add_request(KIND_UNUSED, 2, 0);        // unknown kind
        // ladder through every attempt up to the drop to idle
        repeat (RETRY_LEVELS)
        begin
            add_request(KIND_START, 1, 0);
            add_request(KIND_START, 2, 0);
        end
        add_request(KIND_STAT, 0, RETRY_LEVELS - 1);
        add_request(KIND_STAT, 0, 7);          // level past the last attempt
        wait_for_quiet();

        // three senders, goal zero; long receiver hold-off, then a full drain mid-phase
        program_register(REG_SENSOR_COUNT, 16'd3);
        program_register(REG_PACKET_GOAL, 16'd0);
        queue_random(60);
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        wait_for_quiet();
        queue_random(60);
        wait_for_quiet();

        // single sender, no collisions possible
        program_register(REG_SENSOR_COUNT, 16'd1);
        program_register(REG_PACKET_GOAL, 16'd2);
        queue_random(60);
        wait_for_quiet();

        // upper data bits set, register keeps the low eleven
        program_register(REG_PACKET_GOAL, 16'd1);
        program_register(REG_SENSOR_COUNT, 16'hF805);
        queue_random(120);
        wait_for_quiet();

        // full table, goal one below the maximum
        program_register(REG_SENSOR_COUNT, 16'd1024);
        program_register(REG_PACKET_GOAL, 16'hFFFE);
        queue_random(100);
        wait_for_quiet();

        // count past the table size acts as a full table
        program_register(REG_SENSOR_COUNT, 16'd2047);
        program_register(REG_PACKET_GOAL, 16'd3);
        queue_random(60);
        wait_for_quiet();

        // no sender in use: everything but statistics is ignored, all done
        program_register(REG_SENSOR_COUNT, 16'd0);
        program_register(REG_PACKET_GOAL, 16'd0);
        queue_random(20);
        wait_for_quiet();

        // two senders with no idling on either side
        program_register(REG_SENSOR_COUNT, 16'd2);
        program_register(REG_PACKET_GOAL, 16'd1000);
        set_idling(1'b0, 1'b0);
        queue_random(120);
        wait_for_quiet();

        // one sender runs its packet count past the goal and into saturation
        program_register(REG_SENSOR_COUNT, 16'd1);
        program_register(REG_PACKET_GOAL, 16'hFFFE);
        for (k = 0; k < 65540; k++)
        begin
            add_request(KIND_START, 0, 0);
            add_request(KIND_END, 0, 0);
        end
        add_request(KIND_STAT, 0, 0);
        wait_for_quiet();

        // recount with the saturated sender, back to normal idling
        program_register(REG_SENSOR_COUNT, 16'd2);
        program_register(REG_PACKET_GOAL, 16'hFFFE);
        set_idling(1'b1, 1'b1);
        queue_random(40);
        wait_for_quiet();

        repeat (8) @(posedge clk);

        top_packets = 0;
        for (k = 0; k < MAX_SENSORS; k++)
            if (delivered[k] > top_packets)
                top_packets = delivered[k];
        $display("covered %0d requests, %0d results, %0d collisions, %0d register writes",
                 requests_taken, results_seen, collision_events, register_writes);
        $display("deepest attempt level %0d, highest packet count %0d, done senders %0d",
                 deepest_level, top_packets, done_count);
        if (mismatch_count == 0)
            $display("retry_level_collision_tracker_top_test: done, clean");
        else
            $display("retry_level_collision_tracker_top_test: done, errors");
        $finish;
    end

endmodule
